>>> hdl/firlt_pkg.sv
// ---------------------------------------------------------------------------
// firlt_pkg: shared types and constants for the loadable-tap FIR filter
// Field widths, opcodes, accumulator limits and the MAC control bundle.
// ---------------------------------------------------------------------------
package firlt_pkg;

  localparam int DATA_W = 16;
  localparam int ACC_W  = 32;
  localparam int CNT_W  = 5;

  // opcodes of an input item
  localparam logic OP_COEF   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [CNT_W-1:0] TAP_COUNT_RESET = 5'd3;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 32'sh8000_0000;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // control from the tap sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;     // start a new sum
    logic rd_valid;  // memory read data holds one tap this cycle
    logic tap_ok;    // tap is live (coefficient written, sample seen)
  } mac_ctl_t;

endpackage

>>> hdl/firlt_ram.sv
// ---------------------------------------------------------------------------
// firlt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined at reset.
// ---------------------------------------------------------------------------
module firlt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/firlt_mac.sv
// ---------------------------------------------------------------------------
// firlt_mac: shared multiply-accumulate unit
// Registers one Q30 product per tap, then adds it into a 32-bit
// accumulator that saturates at every add.
// ---------------------------------------------------------------------------
module firlt_mac
  import firlt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mac_ctl_t ctl,
  input  data_t    coef,
  input  data_t    sample,
  output acc_t     acc,
  output logic     busy
);

  acc_t             prod;
  logic             prod_v;
  logic [ACC_W:0]   sum;
  acc_t             acc_next;

  // saturating add of the held product
  always_comb begin
    sum = {acc[ACC_W-1], acc} + {prod[ACC_W-1], prod};
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      acc_next = sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_next = sum[ACC_W-1:0];
    end
  end

  // product stage: valid bit is control, data needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= ctl.rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_valid) begin
      prod <= ctl.tap_ok ? acc_t'(coef) * acc_t'(sample) : '0;
    end
  end

  // accumulate, clear on a new sample
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctl.clear) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc_next;
    end
  end

  assign busy = prod_v;

  assert property (@(posedge clk) disable iff (rst) ctl.clear |-> !prod_v)
    else $error("accumulator cleared while a product is pending");
  assert property (@(posedge clk) disable iff (rst) ctl.clear |=> acc == '0)
    else $error("accumulator not cleared");
  assert property (@(posedge clk) disable iff (rst)
      ctl.rd_valid && !ctl.tap_ok |=> prod == '0)
    else $error("masked tap gave a nonzero product");

endmodule

>>> hdl/fir_filter_loadable_taps_unit.sv
// ---------------------------------------------------------------------------
// fir_filter_loadable_taps_unit: direct-form FIR filter, loadable Q15 taps
// Operation: one shared MAC walks the taps of a sample item, one memory
//   read per cycle, over n = min(tap_count, TAPS) taps; coefficient items
//   are written to the store directly. Throughput: one coefficient item per
//   cycle while idle; no new item is taken until the result of a sample item
//   is delivered. Reset: tap_count = 3, delay line and coefficients
//   read as zero (valid bits and a sample fill count; no clearing pass).
// ---------------------------------------------------------------------------
module fir_filter_loadable_taps_unit
  import firlt_pkg::*;
#(
  parameter int TAPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               opcode,
  input  logic [3:0]         coef_index,
  input  logic signed [15:0] data_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] filtered_value,
  input  logic               cfg_we,
  input  logic [CNT_W-1:0]   cfg_wdata
);

  localparam int AW = $clog2(TAPS);
  localparam int KW = $clog2(TAPS + 1);
  localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} state_t;

  state_t           state;
  logic [CNT_W-1:0] tap_count;
  logic [TAPS-1:0]  coef_vld;
  logic [KW-1:0]    fill;
  logic [KW-1:0]    k;
  logic [KW-1:0]    n;
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic             rd_v;
  logic             tap_ok;
  logic             accept;
  logic             coef_we;
  logic             dly_we;
  logic             issue;
  logic [AW-1:0]    coef_waddr;
  data_t            coef_rd;
  data_t            dly_rd;
  acc_t             acc;
  logic             mac_busy;
  mac_ctl_t         mac_ctl;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign coef_waddr = AW'(coef_index);
  assign coef_we  = accept && (opcode == OP_COEF) && (32'(coef_index) < 32'(TAPS));
  assign dly_we   = accept && (opcode == OP_SAMPLE);
  assign issue    = (state == S_RUN) && (k < n);

  // clamp the tap count to the store depth
  always_comb begin
    if (int'(tap_count) > TAPS) begin
      n = KW'(TAPS);
    end else begin
      n = KW'(tap_count);
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAP_COUNT_RESET;
    end else if (cfg_we) begin
      tap_count <= cfg_wdata;
    end
  end

  // coefficient store, valid bit per entry
  firlt_ram #(.WIDTH(DATA_W), .DEPTH(TAPS)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (data_value),
    .raddr (k[AW-1:0]),
    .rdata (coef_rd)
  );

  // delay line as a circular buffer, written at wptr; the walk starts at the newest sample
  firlt_ram #(.WIDTH(DATA_W), .DEPTH(TAPS)) u_dly_ram (
    .clk   (clk),
    .we    (dly_we),
    .waddr (wptr),
    .wdata (data_value),
    .raddr (rptr),
    .rdata (dly_rd)
  );

  // sequencer: accept, walk taps, drain, deliver
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      coef_vld  <= '0;
      fill      <= '0;
      wptr      <= '0;
      rptr      <= '0;
      k         <= '0;
      rd_v      <= 1'b0;
      tap_ok    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // drop a taken item unless a new one is loaded this cycle
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      if (coef_we) begin
        coef_vld[coef_waddr] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          rd_v <= 1'b0;
          if (dly_we) begin
            rptr  <= wptr;
            wptr  <= (wptr == LAST) ? '0 : wptr + 1'b1;
            fill  <= (fill == KW'(TAPS)) ? fill : fill + 1'b1;
            k     <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          rd_v <= issue;
          if (issue) begin
            tap_ok <= coef_vld[k[AW-1:0]] && (k < fill);
            k      <= k + 1'b1;
            rptr   <= (rptr == '0) ? LAST : rptr - 1'b1;
          end else if (!rd_v && !mac_busy) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || out_ready)) begin
      filtered_value <= acc;
    end
  end

  assign mac_ctl.clear    = dly_we;
  assign mac_ctl.rd_valid = rd_v;
  assign mac_ctl.tap_ok   = tap_ok;

  firlt_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .coef   (coef_rd),
    .sample (dly_rd),
    .acc    (acc),
    .busy   (mac_busy)
  );

  assert property (@(posedge clk) disable iff (rst) in_ready |-> !rd_v && !mac_busy)
    else $error("ready while taps are still in flight");
  assert property (@(posedge clk) disable iff (rst) state == S_RUN |-> k <= n)
    else $error("tap walk ran past the tap count");
  assert property (@(posedge clk) disable iff (rst)
      (coef_we || dly_we) |-> state == S_IDLE)
    else $error("memory write outside idle");
  assert property (@(posedge clk) disable iff (rst)
      $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result raised outside delivery");

endmodule
